FILE: hdl/dkhc_pkg.sv
`default_nettype none

package dkhc_pkg;

   localparam int BUCKETS_DEF = 1024;
   localparam int SLOTS_DEF   = 4;

   localparam int CFG_W   = 11;
   localparam int KEY_W   = 64;
   localparam int DEPTH_W = 6;
   localparam int COUNT_W = 58;

   localparam logic [CFG_W-1:0] CSR_RESET = 11'd1024;

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_STORE  = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [KEY_W-1:0]   key;
      logic [DEPTH_W-1:0] depth;
      logic [COUNT_W-1:0] count;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [COUNT_W-1:0] found_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [DEPTH_W-1:0] depth;
      logic [COUNT_W-1:0] count;
   } entry_type;

   localparam int ENTRY_W = KEY_W + DEPTH_W + COUNT_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_BASE,
      S_RD,
      S_CMP,
      S_WR,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/dkhc_ram.sv
`default_nettype none

module dkhc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/depth_keyed_hash_cache_unit.sv
// Operation: a serial restoring divider forms key mod bucket count, then the bucket base is formed,
// then each slot is read and compared in turn, a store then writes its victim slot, and the result
// is loaded into the output register once that register is free.
// One request at a time: req_ready stays low until the previous result is loaded into the output register.
// Reset: synchronous; afterwards a clearing pass writes zero to all BUCKETS*SLOTS entries,
// one per cycle, with req_ready low; bucket_count resets to 1024.
`default_nettype none

module depth_keyed_hash_cache_unit #(
   parameter int BUCKETS = dkhc_pkg::BUCKETS_DEF,
   parameter int SLOTS   = dkhc_pkg::SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire dkhc_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output dkhc_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [dkhc_pkg::CFG_W-1:0]    csr_wdata
);

   localparam int ENTRIES = BUCKETS * SLOTS;
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW      = dkhc_pkg::CFG_W;
   localparam int BW      = $clog2(dkhc_pkg::KEY_W);
   localparam int LW      = dkhc_pkg::DEPTH_W + 1;

   dkhc_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                    csr_ff;
   logic [CW-1:0]                    div_ff, div_in;
   logic [CW-1:0]                    rem_ff, rem_in;
   logic [BW-1:0]                    bit_ff, bit_in;
   logic [SW-1:0]                    slot_ff, slot_in;
   logic [AW-1:0]                    addr_ff, addr_in;
   logic [AW-1:0]                    clr_ff, clr_in;
   logic [AW-1:0]                    victim_ff, victim_in;
   logic [LW-1:0]                    lowest_ff, lowest_in;
   logic                             op_ff, op_in;
   logic [dkhc_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [dkhc_pkg::DEPTH_W-1:0]     depth_ff, depth_in;
   logic [dkhc_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic                             hit_ff, hit_in;
   logic [dkhc_pkg::COUNT_W-1:0]     found_ff, found_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   dkhc_pkg::rsp_type                rsp_ff, rsp_in;

   logic [CW:0]                      trial;
   logic [CW-1:0]                    eff_div;
   logic                             out_load;
   logic                             ram_we;
   logic [AW-1:0]                    ram_waddr;
   dkhc_pkg::entry_type              ram_wdata;
   logic                             ram_re;
   dkhc_pkg::entry_type              ram_rdata;

   dkhc_ram #(
      .WIDTH (dkhc_pkg::ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // effective divisor: zero reads as one, above the table size saturates
   always_comb begin
      priority if (csr_ff == '0) begin
         eff_div = CW'(1);
      end else if (32'(csr_ff) > BUCKETS) begin
         eff_div = CW'(BUCKETS);
      end else begin
         eff_div = csr_ff;
      end
   end

   // one restoring step of key mod divisor; key rotates so it is intact after the last step
   assign trial = {rem_ff, key_ff[dkhc_pkg::KEY_W-1]};

   always_comb begin
      state_in     = state_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      slot_in      = slot_ff;
      addr_in      = addr_ff;
      clr_in       = clr_ff;
      victim_in    = victim_ff;
      lowest_in    = lowest_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      req_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = victim_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      out_load     = 1'b0;

      unique case (state_ff)
         dkhc_pkg::S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            if (clr_ff == AW'(ENTRIES - 1)) begin
               state_in = dkhc_pkg::S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         dkhc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_data.req_type;
               key_in    = req_data.key;
               depth_in  = req_data.depth;
               count_in  = req_data.count;
               div_in    = eff_div;
               rem_in    = '0;
               bit_in    = '0;
               hit_in    = 1'b0;
               found_in  = '0;
               lowest_in = LW'(1) << dkhc_pkg::DEPTH_W;
               victim_in = '0;
               slot_in   = '0;
               state_in  = dkhc_pkg::S_DIV;
            end
         end
         dkhc_pkg::S_DIV: begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = CW'(trial - {1'b0, div_ff});
            end else begin
               rem_in = CW'(trial);
            end
            key_in = {key_ff[dkhc_pkg::KEY_W-2:0], key_ff[dkhc_pkg::KEY_W-1]};
            bit_in = bit_ff + BW'(1);
            if (bit_ff == BW'(dkhc_pkg::KEY_W - 1)) begin
               state_in = dkhc_pkg::S_BASE;
            end
         end
         dkhc_pkg::S_BASE: begin
            addr_in  = AW'(32'(rem_ff) * SLOTS);
            state_in = dkhc_pkg::S_RD;
         end
         dkhc_pkg::S_RD: begin
            ram_re   = 1'b1;
            state_in = dkhc_pkg::S_CMP;
         end
         dkhc_pkg::S_CMP: begin
            if (op_ff == dkhc_pkg::REQ_STORE) begin
               // strict less-than keeps the first slot on a tie
               if ({1'b0, ram_rdata.depth} < lowest_ff) begin
                  lowest_in = {1'b0, ram_rdata.depth};
                  victim_in = addr_ff;
               end
            end else if (!hit_ff && ram_rdata.key == key_ff && ram_rdata.depth == depth_ff) begin
               hit_in   = 1'b1;
               found_in = ram_rdata.count;
            end
            if (slot_ff == SW'(SLOTS - 1)) begin
               state_in = (op_ff == dkhc_pkg::REQ_STORE) ? dkhc_pkg::S_WR : dkhc_pkg::S_DONE;
            end else begin
               slot_in  = slot_ff + SW'(1);
               addr_in  = addr_ff + AW'(1);
               state_in = dkhc_pkg::S_RD;
            end
         end
         dkhc_pkg::S_WR: begin
            ram_we          = 1'b1;
            ram_waddr       = victim_ff;
            ram_wdata.key   = key_ff;
            ram_wdata.depth = depth_ff;
            ram_wdata.count = count_ff;
            state_in        = dkhc_pkg::S_DONE;
         end
         dkhc_pkg::S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = dkhc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dkhc_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_in.hit         = hit_ff;
         rsp_in.found_count = found_ff;
         rsp_valid_in       = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dkhc_pkg::S_CLEAR;
         clr_ff       <= '0;
         csr_ff       <= dkhc_pkg::CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      bit_ff    <= bit_in;
      slot_ff   <= slot_in;
      addr_ff   <= addr_in;
      victim_ff <= victim_in;
      lowest_ff <= lowest_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      depth_ff  <= depth_in;
      count_ff  <= count_in;
      hit_ff    <= hit_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_ram_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == dkhc_pkg::S_CLEAR || state_ff == dkhc_pkg::S_WR))
      else $error("table written outside clear or store write");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dkhc_pkg::S_DIV || state_ff == dkhc_pkg::S_BASE) |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");

   a_store_no_hit: assert property (@(posedge clock) disable iff (reset)
      (out_load && op_ff == dkhc_pkg::REQ_STORE) |=> (!rsp_data.hit && rsp_data.found_count == '0))
      else $error("store request returned a hit");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dkhc_pkg::S_CLEAR) |-> !req_ready)
      else $error("request accepted during clearing pass");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dkhc_pkg::S_DIV) |-> (div_ff != '0))
      else $error("zero divisor in remainder unit");

endmodule

`default_nettype wire

FILE: sim/tb_depth_keyed_hash_cache_unit.sv
`timescale 1ns / 1ps

// Mirror of the bucket/slot store; predicts the response of each request in order.
class hash_cache_mirror;
   localparam int ENTRIES = dkhc_pkg::BUCKETS_DEF * dkhc_pkg::SLOTS_DEF;

   logic [dkhc_pkg::KEY_W-1:0]   slot_key   [ENTRIES];
   logic [dkhc_pkg::DEPTH_W-1:0] slot_depth [ENTRIES];
   logic [dkhc_pkg::COUNT_W-1:0] slot_count [ENTRIES];
   logic [dkhc_pkg::CFG_W-1:0]   bucket_count;
   dkhc_pkg::rsp_type            pending_answers [$];
   int unsigned                  errors, lookups, stores, hits;

   function new();
      foreach (slot_key[i]) begin
         slot_key[i]   = '0;
         slot_depth[i] = '0;
         slot_count[i] = '0;
      end
      bucket_count = dkhc_pkg::CSR_RESET;
      errors  = 0;
      lookups = 0;
      stores  = 0;
      hits    = 0;
   endfunction

   function void note_request(dkhc_pkg::req_type r);
      int unsigned       used, base, victim, lowest;
      logic [63:0]       bucket;
      dkhc_pkg::rsp_type ans;
      ans  = '0;
      used = bucket_count;
      // zero acts as one bucket, anything past the table size saturates
      if (used == 0) used = 1;
      if (used > dkhc_pkg::BUCKETS_DEF) used = dkhc_pkg::BUCKETS_DEF;
      bucket = r.key % {32'd0, used};
      base   = bucket[31:0] * dkhc_pkg::SLOTS_DEF;
      if (r.req_type == dkhc_pkg::REQ_LOOKUP) begin
         lookups++;
         for (int s = 0; s < dkhc_pkg::SLOTS_DEF; s++) begin
            if (slot_key[base+s] == r.key && slot_depth[base+s] == r.depth) begin
               ans.hit         = 1'b1;
               ans.found_count = slot_count[base+s];
               break;
            end
         end
         if (ans.hit) hits++;
      end else begin
         stores++;
         victim = 0;
         lowest = 64;
         // lowest depth is replaced, first slot wins a tie
         for (int s = 0; s < dkhc_pkg::SLOTS_DEF; s++) begin
            if (slot_depth[base+s] < lowest) begin
               lowest = slot_depth[base+s];
               victim = s;
            end
         end
         slot_key[base+victim]   = r.key;
         slot_depth[base+victim] = r.depth;
         slot_count[base+victim] = r.count;
      end
      pending_answers.push_back(ans);
   endfunction

   function void check_answer(dkhc_pkg::rsp_type got);
      dkhc_pkg::rsp_type want;
      if (pending_answers.size() == 0) begin
         errors++;
         $display("%0t: unexpected response: expected none, actual hit=%0b found_count=%0h",
                  $time, got.hit, got.found_count);
      end else begin
         want = pending_answers.pop_front();
         if (got.hit !== want.hit) begin
            errors++;
            $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, got.hit);
         end
         if (got.found_count !== want.found_count) begin
            errors++;
            $display("%0t: found_count mismatch: expected %0h, actual %0h",
                     $time, want.found_count, got.found_count);
         end
      end
   endfunction
endclass

module tb_depth_keyed_hash_cache_unit;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 140;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   dkhc_pkg::req_type          req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   dkhc_pkg::rsp_type          rsp_data;
   logic                       csr_we;
   logic [dkhc_pkg::CFG_W-1:0] csr_wdata;

   int unsigned                send_idle_pct = 0;
   int unsigned                rsp_stall_pct = 0;
   int unsigned                hold_left     = 0;
   logic [dkhc_pkg::KEY_W-1:0] key_pool [16];
   logic [9:0]                 hot_low [3];
   logic [dkhc_pkg::CFG_W-1:0] bucket_settings [PHASES];
   dkhc_pkg::req_type          store_history [$];

   hash_cache_mirror mirror = new();

   depth_keyed_hash_cache_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random stalls, plus a counted hold-off when requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) mirror.check_answer(rsp_data);
         if (req_valid && req_ready) mirror.note_request(req_data);
         if (csr_we) mirror.bucket_count = csr_wdata;
      end
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("FAIL depth_keyed_hash_cache_unit");
      $finish;
   end

   task automatic send_request(input dkhc_pkg::req_type r);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_fields(input logic t, input logic [dkhc_pkg::KEY_W-1:0] k,
                              input logic [dkhc_pkg::DEPTH_W-1:0] d,
                              input logic [dkhc_pkg::COUNT_W-1:0] c);
      dkhc_pkg::req_type r;
      r.req_type = t;
      r.key      = k;
      r.depth    = d;
      r.count    = c;
      send_request(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (mirror.pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_bucket_count(input logic [dkhc_pkg::CFG_W-1:0] v);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // mostly keys that crowd a few buckets and lookups of what was stored
   function automatic dkhc_pkg::req_type make_request();
      dkhc_pkg::req_type r;
      logic [63:0]       rnd;
      int unsigned       pick, idx;
      rnd        = {$urandom, $urandom};
      r.count    = rnd[dkhc_pkg::COUNT_W-1:0];
      r.key      = {$urandom, $urandom};
      r.depth    = 6'($urandom_range(63));
      pick       = $urandom_range(99);
      if (pick < 3) r.count = '1;
      else if (pick < 5) r.count = '0;
      r.req_type = ($urandom_range(99) < 45) ? dkhc_pkg::REQ_STORE : dkhc_pkg::REQ_LOOKUP;
      pick       = $urandom_range(99);
      if (r.req_type == dkhc_pkg::REQ_STORE) begin
         if (pick < 55) begin
            r.key = key_pool[$urandom_range(15)];
         end else if (pick < 75 && store_history.size() != 0) begin
            r.key = store_history[$urandom_range(store_history.size() - 1)].key;
         end
         if ($urandom_range(99) < 60) r.depth = 6'($urandom_range(7));
         store_history.push_back(r);
         if (store_history.size() > 48) void'(store_history.pop_front());
      end else if (store_history.size() != 0 && pick < 80) begin
         idx   = $urandom_range(store_history.size() - 1);
         r.key = store_history[idx].key;
         if (pick < 60) r.depth = store_history[idx].depth;
      end else if (pick < 90) begin
         r.key = key_pool[$urandom_range(15)];
      end
      return r;
   endfunction

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      bucket_settings = '{11'd1, 11'd0, 11'd2047, 11'd13, 11'd1024, 11'd2, 11'd640, 11'd1023};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // cleared slots hold key 0 / depth 0, so this lookup hits with count 0
      send_fields(dkhc_pkg::REQ_LOOKUP, 64'd0, 6'd0, '0);
      send_fields(dkhc_pkg::REQ_LOOKUP, 64'd0, 6'd1, '1);
      send_fields(dkhc_pkg::REQ_LOOKUP, '1, 6'd63, '0);
      // same key and depth twice in one bucket: the first slot answers
      send_fields(dkhc_pkg::REQ_STORE, 64'd5, 6'd5, '1);
      send_fields(dkhc_pkg::REQ_STORE, 64'd5, 6'd5, 58'd1);
      send_fields(dkhc_pkg::REQ_LOOKUP, 64'd5, 6'd5, '0);
      send_fields(dkhc_pkg::REQ_STORE, 64'd1029, 6'd9, 58'd123);
      send_fields(dkhc_pkg::REQ_STORE, 64'd2053, 6'd63, 58'h2AAAAAAAAAAAAAA);
      send_fields(dkhc_pkg::REQ_STORE, 64'd3077, 6'd2, 58'd77);
      send_fields(dkhc_pkg::REQ_LOOKUP, 64'd5, 6'd5, '0);
      send_fields(dkhc_pkg::REQ_LOOKUP, 64'd2053, 6'd63, '0);
      send_fields(dkhc_pkg::REQ_LOOKUP, 64'd1029, 6'd8, '0);
      send_fields(dkhc_pkg::REQ_STORE, 64'd4101, 6'd0, 58'd9);
      send_fields(dkhc_pkg::REQ_LOOKUP, 64'd3077, 6'd2, '0);
      send_fields(dkhc_pkg::REQ_LOOKUP, 64'd4101, 6'd0, '0);
      send_fields(dkhc_pkg::REQ_STORE, '1, 6'd0, '1);
      send_fields(dkhc_pkg::REQ_LOOKUP, '1, 6'd0, '0);
      send_fields(dkhc_pkg::REQ_STORE, '1, 6'd63, '0);
      send_fields(dkhc_pkg::REQ_LOOKUP, '1, 6'd63, '0);
      send_fields(dkhc_pkg::REQ_STORE, 64'h8000_0000_0000_0000, 6'd42, 58'h155555555555555);
      send_fields(dkhc_pkg::REQ_LOOKUP, 64'h8000_0000_0000_0000, 6'd42, '0);
      send_fields(dkhc_pkg::REQ_LOOKUP, 64'h8000_0000_0000_0000, 6'd41, '0);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         send_idle_pct = (p % 4 == 1) ? 54 : (p % 4 == 3) ? 7 : 0;
         rsp_stall_pct = (p % 4 == 2) ? 54 : (p % 4 == 3) ? 7 : 0;
         // long output hold-off so the request side backs up
         if (p == 2) hold_left = 600;
         for (int i = 0; i < 3; i++) hot_low[i] = 10'($urandom);
         for (int i = 0; i < 16; i++) begin
            key_pool[i] = {$urandom, $urandom};
            if (i < 12) key_pool[i][9:0] = hot_low[i % 3];
         end
         write_bucket_count(bucket_settings[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 5 && n == PHASE_ITEMS / 2) wait_drained();
            send_request(make_request());
         end
      end

      wait_drained();
      repeat (80) @(posedge clock);
      $display("Covered %0d lookups (%0d hits) and %0d stores over %0d bucket-count settings,",
               mirror.lookups, mirror.hits, mirror.stores, PHASES + 1);
      $display("with back-to-back, idle-sender, stalled-receiver, mixed and held-off phases.");
      if (mirror.errors == 0 && mirror.pending_answers.size() == 0) begin
         $display("PASS depth_keyed_hash_cache_unit");
      end else begin
         $display("FAIL depth_keyed_hash_cache_unit");
      end
      $finish;
   end
endmodule
